>>> hdl/mlscd_pkg.sv
// Shared types and constants for the mean-luma scene change detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mlscd_pkg;

    // Field and state widths
    localparam int LUMA_W     = 8;
    localparam int DIM_W      = 13;
    localparam int THR_W      = 8;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 24;
    localparam int TOTAL_W    = 25;
    localparam int IDX_W      = 32;
    localparam int QUO_W      = 8;
    localparam int STEP_W     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

    // Frame size limits and register reset values
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd1080;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;

    // Last step of the quotient loop, one quotient bit per step
    localparam logic [STEP_W-1:0] LAST_STEP = 3'(QUO_W - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;        // a sample transaction completes this cycle
        logic frame_end;   // that sample closes the frame
        logic div_step;    // produce one quotient bit
        logic publish;     // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_sample; // next sample reaches the frame size
        logic total_ok;    // frame size product is current
        logic out_free;    // result register can take a new result
    } t_dp_status;

endpackage

>>> hdl/mlscd_datapath.sv
// Datapath of the scene change detector: configuration registers, sample
// accumulator, restoring divider for the frame mean, and result register.
// Depends on mlscd_pkg; sequenced by mlscd_controller.
module mlscd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlscd_pkg::t_dp_cmd                  i_cmd,
    output mlscd_pkg::t_dp_status               o_status,
    input  logic                                i_cfg_we,
    input  logic [mlscd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlscd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [mlscd_pkg::LUMA_W-1:0]        i_luma_sample,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_is_keyframe,
    output logic [mlscd_pkg::IDX_W-1:0]         o_frame_index,
    output logic [mlscd_pkg::LUMA_W-1:0]        o_mean_luma
);

    // Force a dimension into 1..max
    function automatic logic [mlscd_pkg::DIM_W-1:0] clamp_dim(
        input logic [mlscd_pkg::DIM_W-1:0] v,
        input logic [mlscd_pkg::DIM_W-1:0] maxv
    );
        logic [mlscd_pkg::DIM_W-1:0] res;
        if (v == '0) begin
            res = {{(mlscd_pkg::DIM_W-1){1'b0}}, 1'b1};
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [mlscd_pkg::DIM_W-1:0]     r_width;
    logic [mlscd_pkg::DIM_W-1:0]     r_height;
    logic [mlscd_pkg::THR_W-1:0]     r_thr;
    logic [mlscd_pkg::TOTAL_W-1:0]   r_total;
    logic                            r_total_ok;
    logic [mlscd_pkg::SUM_W-1:0]     r_sum;
    logic [mlscd_pkg::CNT_W-1:0]     r_count;
    logic [mlscd_pkg::SUM_W-1:0]     r_rem;
    logic [mlscd_pkg::SUM_W-1:0]     r_dsr;
    logic [mlscd_pkg::QUO_W-1:0]     r_quo;
    logic [mlscd_pkg::LUMA_W-1:0]    r_prev;
    logic [mlscd_pkg::IDX_W-1:0]     r_frame_cnt;
    logic                            r_out_valid;
    logic                            r_out_key;
    logic [mlscd_pkg::IDX_W-1:0]     r_out_idx;
    logic [mlscd_pkg::LUMA_W-1:0]    r_out_mean;

    logic [mlscd_pkg::DIM_W-1:0]     w_wc;
    logic [mlscd_pkg::DIM_W-1:0]     w_hc;
    logic [2*mlscd_pkg::DIM_W-1:0]   w_prod;
    logic [mlscd_pkg::TOTAL_W-1:0]   w_taken;
    logic [mlscd_pkg::SUM_W-1:0]     n_sum;
    logic                            w_ge;
    logic [mlscd_pkg::LUMA_W-1:0]    w_diff;

    // Clamp the configured size and form the frame sample count
    assign w_wc   = clamp_dim(r_width,  mlscd_pkg::DIM_W'(mlscd_pkg::MAX_WIDTH));
    assign w_hc   = clamp_dim(r_height, mlscd_pkg::DIM_W'(mlscd_pkg::MAX_HEIGHT));
    assign w_prod = {{mlscd_pkg::DIM_W{1'b0}}, w_wc} * {{mlscd_pkg::DIM_W{1'b0}}, w_hc};

    // Configuration registers; hold off samples until the product is refreshed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= mlscd_pkg::WIDTH_RESET;
            r_height   <= mlscd_pkg::HEIGHT_RESET;
            r_thr      <= mlscd_pkg::THRESHOLD_RESET;
            r_total_ok <= 1'b0;
        end else begin
            r_total_ok <= !i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mlscd_pkg::REG_FRAME_WIDTH:      r_width  <= i_cfg_data;
                    mlscd_pkg::REG_FRAME_HEIGHT:     r_height <= i_cfg_data;
                    mlscd_pkg::REG_CHANGE_THRESHOLD: r_thr    <= i_cfg_data[mlscd_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= w_prod[mlscd_pkg::TOTAL_W-1:0];
    end

    // Accumulate samples of the current frame
    assign w_taken = {1'b0, r_count} + mlscd_pkg::TOTAL_W'(1);
    assign n_sum   = r_sum + {{(mlscd_pkg::SUM_W-mlscd_pkg::LUMA_W){1'b0}}, i_luma_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.frame_end) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_sum   <= n_sum;
            r_count <= w_taken[mlscd_pkg::CNT_W-1:0];
        end
    end

    // Restoring division, one quotient bit per step, most significant first
    assign w_ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_end) begin
            r_rem <= n_sum;
            r_dsr <= {w_taken, {(mlscd_pkg::SUM_W-mlscd_pkg::TOTAL_W){1'b0}}};
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr <= r_dsr >> 1;
            r_quo <= {r_quo[mlscd_pkg::QUO_W-2:0], w_ge};
        end
    end

    // Compare against the previous mean
    assign w_diff = (r_quo >= r_prev) ? (r_quo - r_prev) : (r_prev - r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_frame_cnt <= '0;
        end else if (i_cmd.publish) begin
            r_prev      <= r_quo;
            r_frame_cnt <= r_frame_cnt + mlscd_pkg::IDX_W'(1);
        end
    end

    // Result register: load on publish, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_key  <= (w_diff > r_thr);
            r_out_idx  <= r_frame_cnt;
            r_out_mean <= r_quo;
        end
    end

    assign o_status.last_sample = (w_taken >= r_total);
    assign o_status.total_ok    = r_total_ok;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_is_keyframe = r_out_key;
    assign o_frame_index = r_out_idx;
    assign o_mean_luma   = r_out_mean;

`ifndef SYNTHESIS
    // Partial remainder stays below twice the shifted divisor, so the mean fits 8 bits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ({1'b0, r_rem} < {r_dsr, 1'b0}))
        else $error("divider remainder out of range");

    // Each published frame advances the frame number by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> (r_frame_cnt == $past(r_frame_cnt) + mlscd_pkg::IDX_W'(1)))
        else $error("frame number did not advance");
`endif

endmodule

>>> hdl/mlscd_controller.sv
// Controller of the scene change detector: sequences accumulation, the
// eight-step division and the result hand-off. Depends on mlscd_pkg.
module mlscd_controller (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mlscd_pkg::t_dp_status  i_status,
    output mlscd_pkg::t_dp_cmd     o_cmd
);

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] S_ACCUM = 2'd0;
    localparam logic [STATE_W-1:0] S_DIV   = 2'd1;
    localparam logic [STATE_W-1:0] S_PUB   = 2'd2;

    logic [STATE_W-1:0]            r_state;
    logic [STATE_W-1:0]            n_state;
    logic [mlscd_pkg::STEP_W-1:0]  r_step;
    logic [mlscd_pkg::STEP_W-1:0]  n_step;
    logic                          w_take;

    // Take samples only while accumulating with a current frame size
    assign o_in_stall = !((r_state == S_ACCUM) && i_status.total_ok);
    assign w_take     = i_in_valid && !o_in_stall;

    assign o_cmd.take      = w_take;
    assign o_cmd.frame_end = w_take && i_status.last_sample;
    assign o_cmd.div_step  = (r_state == S_DIV);
    assign o_cmd.publish   = (r_state == S_PUB) && i_status.out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_ACCUM: begin
                n_step = '0;
                if (w_take && i_status.last_sample) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_step = r_step + mlscd_pkg::STEP_W'(1);
                if (r_step == mlscd_pkg::LAST_STEP) begin
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                if (i_status.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTHESIS
    // A frame-closing sample starts the division at step zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.frame_end |=> (r_state == S_DIV) && (r_step == '0))
        else $error("division did not start after frame end");

    // The full quotient is formed before a result is published
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_PUB) |-> ($past(r_step) == mlscd_pkg::LAST_STEP))
        else $error("result published before division finished");
`endif

endmodule

>>> hdl/mean_luma_scene_change_detector.sv
// Top level of the mean-luma scene change detector.
// Depends on mlscd_pkg, mlscd_controller and mlscd_datapath.
//
// Usage:
//   Luma samples of the active area enter in raster order on the input
//   channel (i_in_valid / o_in_stall / i_luma_sample). A transaction
//   completes when valid is high and stall is low.
//   While input is not stalled, one sample is taken per cycle. On the sample
//   that completes width*height samples, the frame mean is formed by an
//   eight-step restoring divider (one quotient bit per cycle), so input stalls
//   after each frame's last sample until the divider has finished and the
//   result is loaded. The result (o_is_keyframe, o_frame_index, o_mean_luma)
//   appears on the output channel once the division completes and holds in
//   an output register until the receiver takes it; samples of the next
//   frame are taken meanwhile. If the previous result is still stalled when
//   the next mean is ready, input stalls until it is taken.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are applied at
//   once; input stalls in the cycle after each write while the frame size
//   product is refreshed. Reset restores 1920x1080, threshold 10, clears
//   sums, the previous mean and the frame number, and empties the output.
module mean_luma_scene_change_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mlscd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlscd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mlscd_pkg::LUMA_W-1:0]        i_luma_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_is_keyframe,
    output logic [mlscd_pkg::IDX_W-1:0]         o_frame_index,
    output logic [mlscd_pkg::LUMA_W-1:0]        o_mean_luma
);

    mlscd_pkg::t_dp_cmd    w_cmd;
    mlscd_pkg::t_dp_status w_status;

    // Sequencer
    mlscd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Accumulator, divider and result register
    mlscd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_luma_sample (i_luma_sample),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_is_keyframe (o_is_keyframe),
        .o_frame_index (o_frame_index),
        .o_mean_luma   (o_mean_luma)
    );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for mean_luma_scene_change_detector.
// Drives luma frames and register writes with random idling and compares every frame result
// against a scene predictor kept here. Depends on mlscd_pkg and the RTL only.
module testbench;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_SAMPLES = 540;
    localparam int LIMIT_SAMPLES  = 160;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int QUIET_LIMIT    = 4000;

    // Index with no register behind it
    localparam logic [mlscd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                         is_keyframe;
        logic [mlscd_pkg::IDX_W-1:0]  frame_index;
        logic [mlscd_pkg::LUMA_W-1:0] mean_luma;
    } t_scene_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [mlscd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mlscd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [mlscd_pkg::LUMA_W-1:0]     i_luma_sample = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_is_keyframe;
    logic [mlscd_pkg::IDX_W-1:0]      o_frame_index;
    logic [mlscd_pkg::LUMA_W-1:0]     o_mean_luma;

    // Scene predictor state
    logic [mlscd_pkg::DIM_W-1:0]  width_reg = mlscd_pkg::WIDTH_RESET;
    logic [mlscd_pkg::DIM_W-1:0]  height_reg = mlscd_pkg::HEIGHT_RESET;
    logic [mlscd_pkg::THR_W-1:0]  threshold_reg = mlscd_pkg::THRESHOLD_RESET;
    logic [mlscd_pkg::SUM_W-1:0]  luma_total = '0;
    logic [mlscd_pkg::CNT_W-1:0]  pixels_taken = '0;
    logic [mlscd_pkg::LUMA_W-1:0] last_mean = '0;
    logic [mlscd_pkg::IDX_W-1:0]  frames_done = '0;

    t_scene_result pending_scene_results[$];

    int samples_sent = 0;
    int mismatches = 0;
    int gap_pct = 20;
    int stall_pct = 30;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;
    int quiet_cycles = 0;

    mean_luma_scene_change_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_luma_sample (i_luma_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_keyframe (o_is_keyframe),
        .o_frame_index (o_frame_index),
        .o_mean_luma   (o_mean_luma)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Zero means one, anything above the limit saturates
    function automatic int unsigned active_size(logic [mlscd_pkg::DIM_W-1:0] value,
                                                int unsigned limit);
        int unsigned v;
        v = 32'(value);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // Random luma around a level, clipped to the 8-bit range
    function automatic logic [mlscd_pkg::LUMA_W-1:0] luma_near(int level, int spread);
        int v;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return mlscd_pkg::LUMA_W'(v);
    endfunction

    // Accumulate one sample; close the frame once the count reaches the current size
    task automatic fold_luma_into_frame(input logic [mlscd_pkg::LUMA_W-1:0] luma);
        longint unsigned frame_total;
        longint unsigned taken;
        logic [mlscd_pkg::LUMA_W-1:0] mean;
        logic [mlscd_pkg::LUMA_W-1:0] delta;
        t_scene_result res;
        frame_total = longint'(active_size(width_reg, mlscd_pkg::MAX_WIDTH))
                    * longint'(active_size(height_reg, mlscd_pkg::MAX_HEIGHT));
        luma_total = luma_total + mlscd_pkg::SUM_W'(luma);
        taken = longint'(pixels_taken) + 1;
        if (taken < frame_total) begin
            pixels_taken = mlscd_pkg::CNT_W'(taken);
        end else begin
            mean = mlscd_pkg::LUMA_W'(longint'(luma_total) / taken);
            delta = (mean >= last_mean) ? mean - last_mean : last_mean - mean;
            res.is_keyframe = (delta > threshold_reg);
            res.frame_index = frames_done;
            res.mean_luma = mean;
            pending_scene_results.push_back(res);
            last_mean = mean;
            frames_done = frames_done + mlscd_pkg::IDX_W'(1);
            luma_total = '0;
            pixels_taken = '0;
        end
    endtask

    // Offer one sample after an optional gap and hold it until the transaction completes
    task automatic send_luma(input logic [mlscd_pkg::LUMA_W-1:0] luma);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_luma_sample <= luma;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fold_luma_into_frame(luma);
        samples_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle_block;
        i_in_valid <= 1'b0;
        while (pending_scene_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mlscd_pkg::CFG_IDX_W-1:0] reg_sel,
                             input logic [mlscd_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (reg_sel)
            mlscd_pkg::REG_FRAME_WIDTH: width_reg = value;
            mlscd_pkg::REG_FRAME_HEIGHT: height_reg = value;
            mlscd_pkg::REG_CHANGE_THRESHOLD: threshold_reg = value[mlscd_pkg::THR_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One-sample frames: keyframe decision around the threshold, default threshold first
    task automatic test_threshold_edges;
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd1);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd1);
        send_luma(8'd10);
        send_luma(8'd21);
        send_luma(8'd21);
        send_luma(8'd0);
        send_luma(8'd255);
        settle_block();
        write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd255);
        send_luma(8'd0);
        settle_block();
        write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd254);
        send_luma(8'd255);
        settle_block();
        write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd0);
        send_luma(8'd255);
        send_luma(8'd254);
        settle_block();
        // upper data bits must be dropped: threshold becomes 5
        write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'h1F05);
        send_luma(8'd248);
        send_luma(8'd252);
    endtask

    // Truncating mean, ignored register index, and a frame cut short by a smaller size
    task automatic test_resize_mid_frame;
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd2);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd2);
        send_luma(8'd255);
        send_luma(8'd255);
        send_luma(8'd255);
        send_luma(8'd254);
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd4);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd4);
        send_luma(8'd200);
        send_luma(8'd100);
        send_luma(8'd50);
        send_luma(8'd0);
        send_luma(8'd255);
        settle_block();
        write_reg(REG_SPARE, 13'h1FFF);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd1);
        send_luma(8'd7);
    endtask

    // Zero and oversized dimensions: no frame closes early, then a shrink closes it
    task automatic test_size_limits;
        int k;
        settle_block();
        gap_pct = 5;
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd0);
        for (k = 0; k < LIMIT_SAMPLES; k++) begin
            send_luma(mlscd_pkg::LUMA_W'($urandom_range(0, 255)));
        end
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd16);
        send_luma(mlscd_pkg::LUMA_W'($urandom_range(0, 255)));
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd5000);
        for (k = 0; k < LIMIT_SAMPLES; k++) send_luma(8'd255);
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd16);
        send_luma(8'd255);
        gap_pct = 20;
    endtask

    // Receiver holds off for a long stretch while samples keep coming back to back
    task automatic test_output_hold;
        int f;
        int k;
        int level;
        settle_block();
        write_reg(mlscd_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(mlscd_pkg::REG_FRAME_HEIGHT, 13'd1);
        write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd10);
        gap_pct = 0;
        hold_request = 1'b1;
        level = 128;
        for (f = 0; f < 15; f++) begin
            level = int'(luma_near(level, 20));
            for (k = 0; k < 3; k++) send_luma(luma_near(level, 3));
        end
        settle_block();
        gap_pct = 20;
    endtask

    // Random sizes, thresholds and idling; scenes drift or cut, some frames left unfinished
    task automatic test_random_scenes;
        int goal;
        int frame_count;
        int frame_size;
        int part;
        int level;
        int spread;
        int f;
        int k;
        goal = samples_sent + RANDOM_SAMPLES;
        level = 128;
        while (samples_sent < goal) begin
            settle_block();
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 60;
            endcase
            write_reg(mlscd_pkg::REG_FRAME_WIDTH,
                      mlscd_pkg::CFG_DATA_W'($urandom_range(0, 7)));
            write_reg(mlscd_pkg::REG_FRAME_HEIGHT,
                      mlscd_pkg::CFG_DATA_W'($urandom_range(0, 4)));
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0: write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd0);
                    1: write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD, 13'd255);
                    2, 3: write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD,
                                    mlscd_pkg::CFG_DATA_W'($urandom_range(0, 30)));
                    default: write_reg(mlscd_pkg::REG_CHANGE_THRESHOLD,
                                       mlscd_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                endcase
            end
            frame_size = int'(active_size(width_reg, mlscd_pkg::MAX_WIDTH)
                            * active_size(height_reg, mlscd_pkg::MAX_HEIGHT));
            frame_count = $urandom_range(1, 6);
            for (f = 0; f < frame_count; f++) begin
                if ($urandom_range(0, 1) == 1) level = $urandom_range(0, 255);
                else level = int'(luma_near(level, 15));
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 128;
                    default: spread = 4;
                endcase
                for (k = 0; k < frame_size; k++) send_luma(luma_near(level, spread));
            end
            // leave a frame unfinished so the next size lands mid-frame
            if (frame_size > 1 && $urandom_range(0, 4) == 0) begin
                part = $urandom_range(1, frame_size - 1);
                for (k = 0; k < part; k++) begin
                    send_luma(mlscd_pkg::LUMA_W'($urandom_range(0, 255)));
                end
            end
        end
        stall_pct = 30;
        gap_pct = 20;
    endtask

    // Output stall: one long hold on request, otherwise random bursts and free runs
    initial begin : out_receiver
        int run_left;
        int held;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                i_out_stall <= 1'b1;
                for (held = 1; held < HOLD_CYCLES; held++) @(posedge i_clk);
                run_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
                run_left = $urandom_range(0, 19);
            end
        end
    end

    // Compare each result transaction with the oldest pending prediction
    always @(posedge i_clk) begin : result_check
        t_scene_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_scene_results.size() == 0) begin
                $display("%0t unexpected result: frame_index %0d mean_luma %0d is_keyframe %0b",
                         $time, o_frame_index, o_mean_luma, o_is_keyframe);
                mismatches++;
            end else begin
                want = pending_scene_results.pop_front();
                if (o_frame_index !== want.frame_index) begin
                    $display("%0t frame_index: expected %0d, actual %0d",
                             $time, want.frame_index, o_frame_index);
                    mismatches++;
                end
                if (o_mean_luma !== want.mean_luma) begin
                    $display("%0t mean_luma (frame %0d): expected %0d, actual %0d",
                             $time, want.frame_index, want.mean_luma, o_mean_luma);
                    mismatches++;
                end
                if (o_is_keyframe !== want.is_keyframe) begin
                    $display("%0t is_keyframe (frame %0d): expected %0b, actual %0b",
                             $time, want.frame_index, want.is_keyframe, o_is_keyframe);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no transaction completes for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("mean_luma_scene_change_detector: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_threshold_edges();
        test_resize_mid_frame();
        test_size_limits();
        test_output_hold();
        test_random_scenes();
        settle_block();
        if (mismatches == 0) begin
            $display("mean_luma_scene_change_detector: match");
        end else begin
            $display("mean_luma_scene_change_detector: mismatch");
        end
        $finish;
    end

endmodule
